// ===== rtl/simplex_qp_active_set_2d_macros.svh =====
// Assertion macros shared by the block's checker.
`ifndef SIMPLEX_QP_ACTIVE_SET_2D_MACROS_SVH
`define SIMPLEX_QP_ACTIVE_SET_2D_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SQP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqp same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SQP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqp next-cycle check failed");

`endif

// ===== rtl/sqp_pkg.sv =====
// Types and constants of the two-variable simplex QP solver.
package sqp_pkg;

    localparam int DEF_MAX_ITERATIONS = 64;
    localparam int DEF_FRACTION_BITS  = 16;

    localparam logic [15:0] TOL_RESET = 16'd16;
    localparam logic [6:0]  LIM_RESET = 7'd64;

    // configuration register indexes
    localparam logic CFG_TOLERANCE  = 1'b0;
    localparam logic CFG_ITER_LIMIT = 1'b1;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_MUL    = 13'b0000000000010,
        ST_PRE    = 13'b0000000000100,
        ST_DSET   = 13'b0000000001000,
        ST_DRUN   = 13'b0000000010000,
        ST_DEND   = 13'b0000000100000,
        ST_LOOP   = 13'b0000001000000,
        ST_STEP   = 13'b0000010000000,
        ST_DECIDE = 13'b0000100000000,
        ST_CLAMP  = 13'b0001000000000,
        ST_MOVE   = 13'b0010000000000,
        ST_COUNT  = 13'b0100000000000,
        ST_DONE   = 13'b1000000000000
    } t_state;

    // divider jobs
    typedef enum logic [2:0] {
        DV_Q0, DV_Q1, DV_QD, DV_QA, DV_PZ, DV_R0, DV_R1, DV_R2
    } t_dcode;

    // multiplier jobs
    typedef enum logic [3:0] {
        MO_AD, MO_BB, MO_DC0, MO_BC1, MO_AC1, MO_BC0,
        MO_AX0, MO_BX1, MO_BX0, MO_DX1, MO_AP0, MO_AP1
    } t_mop;

endpackage

// ===== rtl/simplex_qp_active_set_2d.sv =====
// Active-set QP solver over the unit triangle, one shared multiplier and one shared divider.
// Work per item: setup of 6 multiplies plus 5 divides, then per pass 4 multiplies and, when
//   the pass moves, up to 3 divides and 2 multiplies; Q16.16 with the default FRACTION_BITS.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: synchronous active-low i_rst_n idles the sequencer, drops the result and loads the
//   tolerance and iteration limit defaults.
module simplex_qp_active_set_2d #(
    parameter int MAX_ITERATIONS = sqp_pkg::DEF_MAX_ITERATIONS,
    parameter int FRACTION_BITS  = sqp_pkg::DEF_FRACTION_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_g_00,
    input  logic signed [31:0] i_g_01,
    input  logic signed [31:0] i_g_11,
    input  logic signed [31:0] i_lin_0,
    input  logic signed [31:0] i_lin_1,
    input  logic signed [31:0] i_start_0,
    input  logic signed [31:0] i_start_1,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_solution_0,
    output logic signed [31:0] o_solution_1,
    output logic               o_limit_hit,
    output logic [6:0]         o_steps_taken
);
    import sqp_pkg::*;

    localparam int FB  = FRACTION_BITS;
    localparam int MW  = 64 - FB;            // width of a shifted product
    localparam int SW  = MW + 2;             // width of exact sums
    localparam int DW  = 32 + FB;            // dividend and quotient width
    localparam int DCW = $clog2(DW + 1);
    localparam int KW  = $clog2(MAX_ITERATIONS + 1);
    localparam int LW  = KW + 7;

    localparam logic signed [SW-1:0] ONE_W     = SW'(1) << FB;
    localparam logic signed [SW-1:0] HALF_W    = SW'(1) << (FB - 1);
    localparam logic signed [SW-1:0] SAT_MAX_W = SW'(32'sh7FFF_FFFF);
    localparam logic signed [SW-1:0] SAT_MIN_W = SW'(32'sh8000_0000);
    localparam logic signed [31:0]   ONE32     = ONE_W[31:0];
    localparam logic signed [31:0]   MAX32     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]   MIN32     = 32'sh8000_0000;

    // Clip an exact sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        if (v > SAT_MAX_W) return MAX32;
        if (v < SAT_MIN_W) return MIN32;
        return v[31:0];
    endfunction

    // True when |v| is within the tolerance.
    function automatic logic le_tol(input logic signed [SW-1:0] v, input logic [15:0] t);
        logic signed [SW-1:0] m;
        m = (v < 0) ? -v : v;
        return m <= $signed(SW'(t));
    endfunction

    // configuration registers
    logic [15:0] r_tol;
    logic [6:0]  r_lim;

    // sequencer
    t_state r_st;
    t_state r_ret;
    t_mop   r_op;
    t_mop   r_op_end;
    t_dcode r_dcode;

    // problem and iterate
    logic signed [31:0] r_a, r_b, r_d, r_c0, r_c1, r_x0, r_x1;
    logic signed [31:0] r_det, r_n0, r_n1, r_den, r_num;
    logic signed [31:0] r_y0, r_y1, r_p0, r_p1;
    logic signed [31:0] r_negx0, r_negx1, r_slack, r_psum, r_alpha;
    logic [2:0]         r_ibnd;
    logic [1:0]         r_which;
    logic               r_whv;
    logic [2:0]         r_act;
    logic [KW-1:0]      r_k;
    logic               r_hit;

    // product and quotient store, one slot per job
    logic signed [MW-1:0] r_m [12];
    logic signed [31:0]   r_q [8];

    // divider
    logic [DW-1:0]  r_dnum;
    logic [31:0]    r_dden;
    logic [31:0]    r_rem;
    logic [DCW-1:0] r_dcnt;
    logic           r_dneg, r_dzero, r_dapos, r_daneg;

    // result register
    logic               r_out_valid;
    logic signed [31:0] r_sol0, r_sol1;
    logic               r_out_hit;
    logic [6:0]         r_steps;

    // shared multiplier: operands picked by the current job
    logic signed [31:0]   w_mul_a, w_mul_b;
    logic signed [63:0]   w_prod;
    logic signed [MW-1:0] w_fx;

    always_comb begin
        unique case (r_op)
            MO_AD:   begin w_mul_a = r_a;     w_mul_b = r_d;  end
            MO_BB:   begin w_mul_a = r_b;     w_mul_b = r_b;  end
            MO_DC0:  begin w_mul_a = r_d;     w_mul_b = r_c0; end
            MO_BC1:  begin w_mul_a = r_b;     w_mul_b = r_c1; end
            MO_AC1:  begin w_mul_a = r_a;     w_mul_b = r_c1; end
            MO_BC0:  begin w_mul_a = r_b;     w_mul_b = r_c0; end
            MO_AX0:  begin w_mul_a = r_a;     w_mul_b = r_x0; end
            MO_BX1:  begin w_mul_a = r_b;     w_mul_b = r_x1; end
            MO_BX0:  begin w_mul_a = r_b;     w_mul_b = r_x0; end
            MO_DX1:  begin w_mul_a = r_d;     w_mul_b = r_x1; end
            MO_AP0:  begin w_mul_a = r_alpha; w_mul_b = r_p0; end
            MO_AP1:  begin w_mul_a = r_alpha; w_mul_b = r_p1; end
            default: begin w_mul_a = '0;      w_mul_b = '0;   end
        endcase
    end

    // arithmetic shift gives the floor of the scaled product
    assign w_prod = w_mul_a * w_mul_b;
    assign w_fx   = w_prod[63:FB];

    // divider operands picked by the current job
    logic signed [31:0] w_dsa, w_dsb;
    logic [31:0]        w_dabs_a, w_dabs_b;

    always_comb begin
        unique case (r_dcode)
            DV_Q0: begin w_dsa = r_n0;    w_dsb = r_det;  end
            DV_Q1: begin w_dsa = r_n1;    w_dsb = r_det;  end
            DV_QD: begin w_dsa = r_c1;    w_dsb = r_d;    end
            DV_QA: begin w_dsa = r_c0;    w_dsb = r_a;    end
            DV_PZ: begin w_dsa = r_num;   w_dsb = r_den;  end
            DV_R0: begin w_dsa = r_negx0; w_dsb = r_p0;   end
            DV_R1: begin w_dsa = r_negx1; w_dsb = r_p1;   end
            DV_R2: begin w_dsa = r_slack; w_dsb = r_psum; end
        endcase
    end

    assign w_dabs_a = w_dsa[31] ? (~$unsigned(w_dsa) + 32'd1) : $unsigned(w_dsa);
    assign w_dabs_b = w_dsb[31] ? (~$unsigned(w_dsb) + 32'd1) : $unsigned(w_dsb);

    // one restoring step per cycle
    logic [32:0] w_t, w_sub;
    logic        w_ge;

    assign w_t   = {r_rem, r_dnum[DW-1]};
    assign w_ge  = w_t >= {1'b0, r_dden};
    assign w_sub = w_t - {1'b0, r_dden};

    // signed, saturated quotient with the divide-by-zero rule
    logic signed [31:0] w_dres;

    always_comb begin
        if (r_dzero) begin
            w_dres = r_dapos ? MAX32 : (r_daneg ? MIN32 : 32'sd0);
        end else if (!r_dneg) begin
            w_dres = (r_dnum > DW'(32'h7FFF_FFFF)) ? MAX32 : $signed(r_dnum[31:0]);
        end else begin
            w_dres = (r_dnum > DW'(33'h0_8000_0000)) ? MIN32 : -$signed(r_dnum[31:0]);
        end
    end

    // active count and pass limit
    logic [1:0]    w_n;
    logic [LW-1:0] w_lim_ext;
    logic [KW-1:0] w_limit;
    logic [KW-1:0] w_kinc;
    logic [LW-1:0] w_kext;
    logic          w_small;

    assign w_n     = 2'(r_act[0]) + 2'(r_act[1]) + 2'(r_act[2]);
    assign w_kinc  = r_k + KW'(1);
    assign w_kext  = LW'(r_k);
    assign w_small = le_tol(SW'(r_p0), r_tol) && le_tol(SW'(r_p1), r_tol);

    always_comb begin
        if (r_lim == 7'd0) begin
            w_lim_ext = LW'(1);
        end else if (LW'(r_lim) > LW'(MAX_ITERATIONS)) begin
            w_lim_ext = LW'(MAX_ITERATIONS);
        end else begin
            w_lim_ext = LW'(r_lim);
        end
    end
    assign w_limit = w_lim_ext[KW-1:0];

    // on a stationary face: stop, or release the constraint picked by the gradient
    logic       w_stop;
    logic [2:0] w_release;

    always_comb begin
        w_stop    = 1'b1;
        w_release = 3'b000;
        case (w_n)
            2'd1: begin
                if (r_act[0]) begin
                    w_stop    = (r_y0 >= 0);
                    w_release = 3'b001;
                end else if (r_act[1]) begin
                    w_stop    = (r_y1 >= 0);
                    w_release = 3'b010;
                end else begin
                    w_stop    = (SW'(r_y0) + SW'(r_y1) <= 0);
                    w_release = 3'b100;
                end
            end
            2'd2: begin
                if (r_act[0] && r_act[1]) begin
                    w_stop    = (r_y0 >= 0) && (r_y1 >= 0);
                    w_release = (r_y0 < r_y1) ? 3'b001 : 3'b010;
                end else if (r_act[0]) begin
                    w_stop    = (r_y1 <= 0) && (r_y1 <= r_y0);
                    w_release = (r_y0 < 0) ? 3'b001 : 3'b100;
                end else begin
                    w_stop    = (r_y0 <= 0) && (r_y0 <= r_y1);
                    w_release = (r_y1 < 0) ? 3'b010 : 3'b100;
                end
            end
            default: w_stop = 1'b1;
        endcase
    end

    // step-length candidate and the clamped step
    logic signed [SW-1:0] w_psum_w;
    logic signed [31:0]   w_alpha_c;

    assign w_psum_w  = SW'(r_p0) + SW'(r_p1);
    assign w_alpha_c = (r_alpha < 0) ? 32'sd0 : r_alpha;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
            r_lim <= LIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOLERANCE:  r_tol <= i_cfg_data;
                CFG_ITER_LIMIT: r_lim <= i_cfg_data[6:0];
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken; ST_DONE reloads it itself
            if (r_out_valid && !i_out_stall && (r_st != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_st)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_a   <= i_g_00;
                        r_b   <= i_g_01;
                        r_d   <= i_g_11;
                        r_c0  <= i_lin_0;
                        r_c1  <= i_lin_1;
                        r_x0  <= i_start_0;
                        r_x1  <= i_start_1;
                        r_act <= {le_tol(ONE_W - SW'(i_start_0) - SW'(i_start_1), r_tol),
                                  le_tol(SW'(i_start_1), r_tol),
                                  le_tol(SW'(i_start_0), r_tol)};
                        r_k      <= '0;
                        r_hit    <= 1'b0;
                        r_op     <= MO_AD;
                        r_op_end <= MO_BC0;
                        r_ret    <= ST_PRE;
                        r_st     <= ST_MUL;
                    end
                end

                // one product per cycle into its slot
                ST_MUL: begin
                    r_m[r_op] <= w_fx;
                    if (r_op == r_op_end) begin
                        r_st <= r_ret;
                    end else begin
                        r_op <= t_mop'(r_op + 4'd1);
                    end
                end

                // terms fixed for the whole item
                ST_PRE: begin
                    r_det   <= sat32(SW'(r_m[MO_AD]) - SW'(r_m[MO_BB]));
                    r_n0    <= sat32(SW'(r_m[MO_DC0]) - SW'(r_m[MO_BC1]));
                    r_n1    <= sat32(SW'(r_m[MO_AC1]) - SW'(r_m[MO_BC0]));
                    r_den   <= sat32(SW'(r_a) - (SW'(r_b) <<< 1) + SW'(r_d));
                    r_num   <= sat32(((SW'(r_d) - SW'(r_a)) >>> 1) + SW'(r_c1) - SW'(r_c0));
                    r_dcode <= DV_Q0;
                    r_st    <= ST_DSET;
                end

                ST_DSET: begin
                    r_dnum  <= {w_dabs_a, {FB{1'b0}}};
                    r_dden  <= w_dabs_b;
                    r_dzero <= (w_dsb == 32'sd0);
                    r_dneg  <= w_dsa[31] ^ w_dsb[31];
                    r_dapos <= (w_dsa > 32'sd0);
                    r_daneg <= w_dsa[31];
                    r_rem   <= '0;
                    r_dcnt  <= DCW'(DW);
                    r_st    <= ST_DRUN;
                end

                // shift in one quotient bit per cycle
                ST_DRUN: begin
                    r_dnum <= {r_dnum[DW-2:0], w_ge};
                    r_rem  <= w_ge ? w_sub[31:0] : w_t[31:0];
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == DCW'(1)) begin
                        r_st <= ST_DEND;
                    end
                end

                ST_DEND: begin
                    r_q[r_dcode] <= w_dres;
                    // keep the nearest boundary, first one wins a tie
                    if ((r_dcode == DV_R0 || r_dcode == DV_R1 || r_dcode == DV_R2)
                        && (w_dres < r_alpha)) begin
                        r_alpha <= w_dres;
                        r_whv   <= 1'b1;
                        r_which <= (r_dcode == DV_R0) ? 2'd0 :
                                   ((r_dcode == DV_R1) ? 2'd1 : 2'd2);
                    end
                    case (r_dcode)
                        DV_Q0: begin r_dcode <= DV_Q1; r_st <= ST_DSET; end
                        DV_Q1: begin r_dcode <= DV_QD; r_st <= ST_DSET; end
                        DV_QD: begin r_dcode <= DV_QA; r_st <= ST_DSET; end
                        DV_QA: begin r_dcode <= DV_PZ; r_st <= ST_DSET; end
                        DV_PZ: r_st <= ST_LOOP;
                        DV_R0: begin
                            if (r_ibnd[1]) begin
                                r_dcode <= DV_R1;
                                r_st    <= ST_DSET;
                            end else if (r_ibnd[2]) begin
                                r_dcode <= DV_R2;
                                r_st    <= ST_DSET;
                            end else begin
                                r_st <= ST_CLAMP;
                            end
                        end
                        DV_R1: begin
                            if (r_ibnd[2]) begin
                                r_dcode <= DV_R2;
                                r_st    <= ST_DSET;
                            end else begin
                                r_st <= ST_CLAMP;
                            end
                        end
                        default: r_st <= ST_CLAMP;
                    endcase
                end

                // start a pass unless every constraint is active
                ST_LOOP: begin
                    if (w_n == 2'd3) begin
                        r_st <= ST_DONE;
                    end else begin
                        r_op     <= MO_AX0;
                        r_op_end <= MO_DX1;
                        r_ret    <= ST_STEP;
                        r_st     <= ST_MUL;
                    end
                end

                // gradient and step for the current face
                ST_STEP: begin
                    r_y0 <= sat32(SW'(r_m[MO_AX0]) + SW'(r_m[MO_BX1]) + SW'(r_c0));
                    r_y1 <= sat32(SW'(r_m[MO_BX0]) + SW'(r_m[MO_DX1]) + SW'(r_c1));
                    if (w_n == 2'd0) begin
                        r_p0 <= sat32(-(SW'(r_x0) + SW'(r_q[DV_Q0])));
                        r_p1 <= sat32(-(SW'(r_x1) + SW'(r_q[DV_Q1])));
                    end else if (w_n == 2'd1) begin
                        if (r_act[0]) begin
                            r_p0 <= sat32(-SW'(r_x0));
                            r_p1 <= sat32(-SW'(r_q[DV_QD]) - SW'(r_x1));
                        end else if (r_act[1]) begin
                            r_p0 <= sat32(-SW'(r_q[DV_QA]) - SW'(r_x0));
                            r_p1 <= sat32(-SW'(r_x1));
                        end else begin
                            r_p0 <= sat32(HALF_W + SW'(r_q[DV_PZ]) - SW'(r_x0));
                            r_p1 <= sat32(HALF_W - SW'(r_q[DV_PZ]) - SW'(r_x1));
                        end
                    end else begin
                        r_p0 <= 32'sd0;
                        r_p1 <= 32'sd0;
                    end
                    r_st <= ST_DECIDE;
                end

                ST_DECIDE: begin
                    if (w_small) begin
                        // stationary on this face: stop or release one constraint
                        r_st <= w_stop ? ST_DONE : ST_COUNT;
                        if (!w_stop) begin
                            r_act <= r_act & ~w_release;
                        end
                    end else begin
                        // clip the step to the boundaries it moves toward
                        r_ibnd  <= {!r_act[2] && (w_psum_w > 0),
                                    !r_act[1] && (r_p1 < 0),
                                    !r_act[0] && (r_p0 < 0)};
                        r_negx0 <= sat32(-SW'(r_x0));
                        r_negx1 <= sat32(-SW'(r_x1));
                        r_slack <= sat32(ONE_W - SW'(r_x0) - SW'(r_x1));
                        r_psum  <= sat32(w_psum_w);
                        r_alpha <= ONE32;
                        r_whv   <= 1'b0;
                        if (!r_act[0] && (r_p0 < 0)) begin
                            r_dcode <= DV_R0;
                            r_st    <= ST_DSET;
                        end else if (!r_act[1] && (r_p1 < 0)) begin
                            r_dcode <= DV_R1;
                            r_st    <= ST_DSET;
                        end else if (!r_act[2] && (w_psum_w > 0)) begin
                            r_dcode <= DV_R2;
                            r_st    <= ST_DSET;
                        end else begin
                            r_st <= ST_CLAMP;
                        end
                    end
                end

                // a blocking boundary becomes active
                ST_CLAMP: begin
                    r_alpha <= w_alpha_c;
                    if (r_whv && (w_alpha_c < ONE32)) begin
                        r_act[r_which] <= 1'b1;
                    end
                    r_op     <= MO_AP0;
                    r_op_end <= MO_AP1;
                    r_ret    <= ST_MOVE;
                    r_st     <= ST_MUL;
                end

                ST_MOVE: begin
                    r_x0 <= sat32(SW'(r_x0) + SW'(r_m[MO_AP0]));
                    r_x1 <= sat32(SW'(r_x1) + SW'(r_m[MO_AP1]));
                    r_st <= ST_COUNT;
                end

                ST_COUNT: begin
                    r_k <= w_kinc;
                    if (w_kinc == w_limit) begin
                        r_hit <= 1'b1;
                        r_st  <= ST_DONE;
                    end else begin
                        r_st <= ST_LOOP;
                    end
                end

                // hold until the result register is free
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_sol0      <= r_x0;
                        r_sol1      <= r_x1;
                        r_out_hit   <= r_hit;
                        r_steps     <= w_kext[6:0];
                        r_out_valid <= 1'b1;
                        r_st        <= ST_IDLE;
                    end
                end

                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_st != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_solution_0  = r_sol0;
    assign o_solution_1  = r_sol1;
    assign o_limit_hit   = r_out_hit;
    assign o_steps_taken = r_steps;

endmodule

// ===== rtl/sqp_checker.sv =====
// Port-level checks of the simplex QP solver, bound to its top level.
`include "simplex_qp_active_set_2d_macros.svh"

module sqp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_solution_0,
    input logic signed [31:0] o_solution_1,
    input logic               o_limit_hit,
    input logic [6:0]         o_steps_taken
);

    // a waiting result holds
    `SQP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_solution_0) && $stable(o_solution_1) && $stable(o_steps_taken))

    // an accepted item makes the block busy
    `SQP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a new result leaves the block ready
    `SQP_ASSERT_SAME(a_ready_with_result, i_clk, i_rst_n, $rose(o_out_valid), !o_in_stall)

    // a limit stop counts at least one pass
    `SQP_ASSERT_SAME(a_limit_counts, i_clk, i_rst_n, o_out_valid && o_limit_hit, o_steps_taken != 7'd0)

endmodule

bind simplex_qp_active_set_2d sqp_checker u_sqp_checker (.*);

// ===== verif/tb_simplex_qp_active_set_2d.sv =====
// Testbench for the two-variable simplex QP solver: directed and random problems checked against a predictor.
module tb_simplex_qp_active_set_2d;
    timeunit 1ns;
    timeprecision 1ps;
    import sqp_pkg::*;

    localparam int      N_RANDOM  = 700;
    localparam int      WD_LIMIT  = 200000;
    localparam longint  ONE_FX    = 64'sd65536;
    localparam longint  HALF_FX   = 64'sd32768;
    localparam int      MAX_ITER  = 64;

    typedef struct {
        logic signed [31:0] g00, g01, g11, l0, l1, s0, s1;
    } t_problem;

    typedef struct {
        logic signed [31:0] x0, x1;
        logic               hit;
        logic [6:0]         steps;
    } t_solution;

    int n_errors;

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, exp);
    endtask

    // Fixed-point helpers for the solver predictor.
    function automatic longint sat(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return (a * b) >>> 16;   // arithmetic shift floors
    endfunction

    function automatic longint fdiv(input longint a, input longint b);
        if (b == 0) return (a > 0) ? 64'sd2147483647 : (a < 0) ? -64'sd2147483648 : 0;
        return sat((a * ONE_FX) / b);
    endfunction

    function automatic longint absv(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // Solve one problem the way the block does.
    function automatic t_solution solve_qp(input t_problem pr, input int tol_raw,
                                           input int lim_raw);
        longint a, b, d, c0, c1, x0, x1, tol;
        longint y0, y1, p0, p1, det, n0, n1, den, num, pz, alpha, r, psum, slack;
        int lim, k, which, n;
        bit hit, i0, i1, i2;
        bit act[3];
        t_solution s;
        a = pr.g00; b = pr.g01; d = pr.g11; c0 = pr.l0; c1 = pr.l1;
        x0 = pr.s0; x1 = pr.s1; tol = tol_raw;
        lim = lim_raw; k = 0; hit = 0;
        if (lim == 0) lim = 1;
        if (lim > MAX_ITER) lim = MAX_ITER;
        act[0] = absv(x0) <= tol;
        act[1] = absv(x1) <= tol;
        act[2] = absv(ONE_FX - x0 - x1) <= tol;
        forever begin
            n = act[0] + act[1] + act[2];
            if (n == 3) break;
            p0 = 0; p1 = 0;
            y0 = sat(fmul(a, x0) + fmul(b, x1) + c0);
            y1 = sat(fmul(b, x0) + fmul(d, x1) + c1);
            if (n == 0) begin
                det = sat(fmul(a, d) - fmul(b, b));
                n0 = sat(fmul(d, c0) - fmul(b, c1));
                n1 = sat(fmul(a, c1) - fmul(b, c0));
                p0 = sat(-(x0 + fdiv(n0, det)));
                p1 = sat(-(x1 + fdiv(n1, det)));
            end else if (n == 1) begin
                if (act[0]) begin
                    p0 = sat(-x0);
                    p1 = sat(-fdiv(c1, d) - x1);
                end else if (act[1]) begin
                    p0 = sat(-fdiv(c0, a) - x0);
                    p1 = sat(-x1);
                end else begin
                    den = sat(a - 2 * b + d);
                    num = sat(((d - a) >>> 1) + c1 - c0);
                    pz = fdiv(num, den);
                    p0 = sat(HALF_FX + pz - x0);
                    p1 = sat(HALF_FX - pz - x1);
                end
            end
            if (absv(p0) <= tol && absv(p1) <= tol) begin
                if (n == 0) break;
                if (n == 1) begin
                    if (act[0]) begin
                        if (y0 >= 0) break;
                        act[0] = 0;
                    end else if (act[1]) begin
                        if (y1 >= 0) break;
                        act[1] = 0;
                    end else begin
                        if (y0 + y1 <= 0) break;
                        act[2] = 0;
                    end
                end else if (act[0] && act[1]) begin
                    if (y0 >= 0 && y1 >= 0) break;
                    if (y0 < y1) act[0] = 0; else act[1] = 0;
                end else if (act[0]) begin
                    if (y1 <= 0 && y1 <= y0) break;
                    if (y0 < 0) act[0] = 0; else act[2] = 0;
                end else begin
                    if (y0 <= 0 && y0 <= y1) break;
                    if (y1 < 0) act[1] = 0; else act[2] = 0;
                end
            end else begin
                alpha = ONE_FX; which = -1;
                psum = sat(p0 + p1);
                i0 = !act[0] && p0 < 0;
                i1 = !act[1] && p1 < 0;
                i2 = !act[2] && (p0 + p1) > 0;
                if (i0 || i1 || i2) begin
                    if (i0) begin
                        r = fdiv(sat(-x0), p0);
                        if (r < alpha) begin alpha = r; which = 0; end
                    end
                    if (i1) begin
                        r = fdiv(sat(-x1), p1);
                        if (r < alpha) begin alpha = r; which = 1; end
                    end
                    if (i2) begin
                        slack = sat(ONE_FX - x0 - x1);
                        r = fdiv(slack, psum);
                        if (r < alpha) begin alpha = r; which = 2; end
                    end
                    if (alpha < 0) alpha = 0;
                    if (alpha > ONE_FX) alpha = ONE_FX;
                    if (alpha < ONE_FX && which >= 0) act[which] = 1;
                end
                x0 = sat(x0 + fmul(alpha, p0));
                x1 = sat(x1 + fmul(alpha, p1));
            end
            k++;
            if (k == lim) begin
                hit = 1;
                break;
            end
        end
        s.x0 = x0[31:0]; s.x1 = x1[31:0]; s.hit = hit; s.steps = k[6:0];
        return s;
    endfunction

    // Scoreboard: queue of predicted solutions, checked in order.
    class solution_board;
        t_solution pending[$];
        int tol_now = 16;
        int lim_now = 64;

        function void note_problem(t_problem pr);
            pending.push_back(solve_qp(pr, tol_now, lim_now));
        endfunction

        task check_solution(t_solution got);
            t_solution e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", got.x0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.x0 !== e.x0) report_mismatch("solution_0", got.x0, e.x0);
            if (got.x1 !== e.x1) report_mismatch("solution_1", got.x1, e.x1);
            if (got.hit !== e.hit) report_mismatch("limit_hit", got.hit, e.hit);
            if (got.steps !== e.steps) report_mismatch("steps_taken", got.steps, e.steps);
        endtask
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic               i_cfg_idx = CFG_TOLERANCE;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic signed [31:0] i_g_00 = 0, i_g_01 = 0, i_g_11 = 0;
    logic signed [31:0] i_lin_0 = 0, i_lin_1 = 0, i_start_0 = 0, i_start_1 = 0;
    logic               o_out_valid;
    logic               i_out_stall = 1;
    logic signed [31:0] o_solution_0, o_solution_1;
    logic               o_limit_hit;
    logic [6:0]         o_steps_taken;

    simplex_qp_active_set_2d dut (.*);

    solution_board board = new();
    bit  feeding_done = 0;
    bit  long_holdoff = 0;
    int  idle_cycles = 0;

    initial forever #4 i_clk = ~i_clk;

    // Count cycles without any accepted item or result; bail out on a hang.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stall per item, one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_holdoff) begin
                i_out_stall <= 1;
                repeat (3000) @(posedge i_clk);
                long_holdoff = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_out_stall <= 1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Collect each accepted result.
    always @(posedge i_clk) begin
        t_solution got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.x0 = o_solution_0; got.x1 = o_solution_1;
            got.hit = o_limit_hit; got.steps = o_steps_taken;
            board.check_solution(got);
        end
    end

    // Offer one problem; hold it until the block takes it.
    task automatic offer_problem(input t_problem pr, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_g_00 <= pr.g00; i_g_01 <= pr.g01; i_g_11 <= pr.g11;
        i_lin_0 <= pr.l0; i_lin_1 <= pr.l1;
        i_start_0 <= pr.s0; i_start_1 <= pr.s1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_problem(pr);
    endtask

    // Drain results, let the block settle, then write one register.
    task automatic write_register(input logic idx, input logic [15:0] val);
        i_in_valid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_TOLERANCE) board.tol_now = int'(val);
        else board.lim_now = int'(val[6:0]);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $signed($urandom_range(0, 8)) - 4;
            2: return 32'sh7fffffff - $urandom_range(0, 1);
            3: return 32'sh80000000 + $urandom_range(0, 1);
            default: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
        endcase
    endfunction

    // Mostly feasible starts with moderate, often convex matrices.
    function automatic t_problem rand_problem();
        t_problem pr;
        int s0, s1;
        if ($urandom_range(0, 9) < 7) begin
            pr.g00 = $urandom_range(0, 32'h40000) - 32'h8000;
            pr.g11 = $urandom_range(0, 32'h40000) - 32'h8000;
            pr.g01 = $signed($urandom_range(0, 32'h30000)) - 32'sh18000;
            pr.l0 = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
            pr.l1 = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
            case ($urandom_range(0, 4))
                0: begin s0 = 0; s1 = $urandom_range(0, 65536); end
                1: begin s0 = $urandom_range(0, 65536); s1 = 0; end
                2: begin s0 = $urandom_range(0, 65536); s1 = 65536 - s0; end
                default: begin
                    s0 = $urandom_range(0, 65536);
                    s1 = $urandom_range(0, 65536 - s0);
                end
            endcase
            pr.s0 = s0; pr.s1 = s1;
        end else begin
            pr.g00 = rand_word(); pr.g01 = rand_word(); pr.g11 = rand_word();
            pr.l0 = rand_word(); pr.l1 = rand_word();
            pr.s0 = rand_word(); pr.s1 = rand_word();
        end
        return pr;
    endfunction

    function automatic t_problem make_problem(input int a, b, d, c0, c1, s0, s1);
        t_problem pr;
        pr.g00 = a; pr.g01 = b; pr.g11 = d; pr.l0 = c0; pr.l1 = c1; pr.s0 = s0; pr.s1 = s1;
        return pr;
    endfunction

    initial begin
        t_problem pr;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: interior, edges, vertices, singular and saturating problems.
        offer_problem(make_problem(32'h20000, 0, 32'h20000, -32'h8000, -32'h8000,
                                   32'h4000, 32'h4000), 0);
        offer_problem(make_problem(32'h10000, 0, 32'h10000, 32'h10000, 32'h10000,
                                   32'h4000, 32'h4000), 0);
        offer_problem(make_problem(32'h10000, 0, 32'h10000, -32'h40000, -32'h40000,
                                   32'h4000, 32'h4000), 0);
        offer_problem(make_problem(32'h10000, 0, 32'h10000, -32'h8000, 32'h10000,
                                   0, 32'h8000), 0);
        offer_problem(make_problem(32'h10000, 0, 32'h10000, 32'h10000, -32'h8000,
                                   32'h8000, 0), 0);
        offer_problem(make_problem(0, 0, 0, 0, 0, 32'h4000, 32'h4000), 0);
        offer_problem(make_problem(0, 0, 0, -32'h10000, 32'h10000, 0, 0), 0);
        offer_problem(make_problem(-32'h10000, 0, -32'h10000, 0, 0, 32'h8000, 32'h8000), 0);
        offer_problem(make_problem(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0);
        offer_problem(make_problem(32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000), 0);
        offer_problem(make_problem(32'h10000, 32'h10000, 32'h10000, 0, 0,
                                   32'h10000, 0), 0);
        offer_problem(make_problem(32'h10000, -32'h10000, 32'h10000, -32'h10000, 0,
                                   0, 32'h10000), 0);
        offer_problem(make_problem(-1, 32'h55555555, 32'h2aaaaaaa, 1, -1, -1, 32'h7ffffffe), 0);

        // Three constraints active needs a huge tolerance; minimal iteration limit too.
        write_register(CFG_TOLERANCE, 16'hffff);
        offer_problem(make_problem(32'h10000, 0, 32'h10000, 0, 0, 32'h4000, 32'h4000), 0);
        offer_problem(rand_problem(), 0);
        write_register(CFG_ITER_LIMIT, 16'd0);
        write_register(CFG_TOLERANCE, 16'd0);
        offer_problem(make_problem(32'h10000, 0, 32'h10000, -32'h40000, 32'h8000,
                                   32'h4000, 32'h4000), 0);
        write_register(CFG_ITER_LIMIT, 16'd1);
        offer_problem(make_problem(32'h10000, 0, 32'h10000, -32'h40000, 32'h8000,
                                   32'h4000, 32'h4000), 0);
        write_register(CFG_ITER_LIMIT, 16'h007f);
        offer_problem(make_problem(32'h10000, 0, 32'h10000, -32'h40000, 32'h8000,
                                   32'h4000, 32'h4000), 0);

        // Random phases over several settings; one back-to-back burst into a held output.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin write_register(CFG_TOLERANCE, 16'd16);
                         write_register(CFG_ITER_LIMIT, 16'd64); end
                1: write_register(CFG_TOLERANCE, 16'($urandom_range(0, 255)));
                2: write_register(CFG_ITER_LIMIT, 16'($urandom_range(1, 8)));
                3: write_register(CFG_TOLERANCE, 16'hffff);
                4: begin write_register(CFG_TOLERANCE, 16'h5a5a);
                         write_register(CFG_ITER_LIMIT, 16'h2a); end
                5: begin write_register(CFG_TOLERANCE, 16'h0000);
                         write_register(CFG_ITER_LIMIT, 16'd64); end
                default: write_register(CFG_TOLERANCE, 16'($urandom_range(1, 64)));
            endcase
            if (ph == 2) long_holdoff = 1;
            for (int i = 0; i < N_RANDOM / 7; i++)
                offer_problem(rand_problem(), (ph == 2 && i < 10));
        end
        i_in_valid <= 0;
        feeding_done = 1;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sqp_pkg.sv
rtl/simplex_qp_active_set_2d.sv
rtl/sqp_checker.sv
verif/tb_simplex_qp_active_set_2d.sv
